// ----- sv/sfrp_pkg.sv -----
// Package for the H.264 SPS frame rate parser: shared types, syntax element
// codes and the fixed-width table used by the bit-serial parser.
// No dependencies.
`default_nettype none
package sfrp_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam logic [4:0]  NalTypeSps = 5'd7;
  localparam logic [7:0]  EpbByte    = 8'h03;
  localparam logic [31:0] RateLimit  = 32'd2000000000;
  localparam logic [31:0] UnitsLimit = 32'd1000000000;
  localparam logic [7:0]  ArIdcExt   = 8'd255;

  // Register indexes of the configuration port
  localparam logic CfgMinFps = 1'b0;
  localparam logic CfgMaxFps = 1'b1;

  // How the back end treats one queued byte
  typedef enum logic [1:0] {
    K_FIRST_OK,
    K_FIRST_BAD,
    K_FEED,
    K_SKIP
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
    logic       len_ok;
  } entry_t;

  // SPS / VUI syntax elements walked up to the timing fields
  typedef enum logic [5:0] {
    P_PROFILE, P_CONLEV, P_SPSID, P_CHROMA, P_SEPCOL, P_BDL, P_BDC, P_QPB,
    P_SCAL, P_LOG2FN, P_POCT, P_LOG2POC, P_DELTA0, P_OFFNR, P_OFFTB, P_NCYC,
    P_CYCOFF, P_MAXREF, P_GAPS, P_WIDTH, P_HEIGHT, P_FMO, P_MBAFF, P_D8,
    P_CROPF, P_CROP, P_VUIF, P_ARF, P_ARIDC, P_SAR, P_OVF, P_OVA, P_VSF,
    P_VFMT, P_VFR, P_CDF, P_COLR, P_CLF, P_CLT, P_CLB, P_TIF, P_UIT, P_TS,
    P_DONE, P_FAIL
  } pos_e;

  typedef enum logic [1:0] {
    PS_IDLE,
    PS_BITS,
    PS_REQ
  } pstate_e;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_GCD,
    RS_DIVN,
    RS_DIVD,
    RS_MUL,
    RS_CMP,
    RS_OUT
  } rstate_e;

  // Timing request handed from the parser to the rate unit
  typedef struct packed {
    logic        len_ok;
    logic        done;
    logic [31:0] uit;
    logic [31:0] ts;
  } rate_req_t;

  // Fixed width of an element; zero means ue(v)
  function automatic logic [5:0] elem_width(pos_e p);
    logic [5:0] w;
    w = 6'd0;
    unique case (p)
      P_PROFILE, P_ARIDC: w = 6'd8;
      P_CONLEV:           w = 6'd16;
      P_VFMT:             w = 6'd3;
      P_COLR:             w = 6'd24;
      P_SAR, P_UIT, P_TS: w = 6'd32;
      P_SEPCOL, P_QPB, P_SCAL, P_DELTA0, P_GAPS, P_FMO, P_MBAFF, P_D8,
      P_CROPF, P_VUIF, P_ARF, P_OVF, P_OVA, P_VSF, P_VFR, P_CDF, P_CLF,
      P_TIF:              w = 6'd1;
      default:            w = 6'd0;
    endcase
    return w;
  endfunction

  function automatic logic high_profile(logic [31:0] v);
    logic hp;
    hp = 1'b0;
    case (v)
      32'd44, 32'd83, 32'd86, 32'd100, 32'd110, 32'd118,
      32'd122, 32'd128, 32'd134, 32'd138, 32'd139, 32'd244: hp = 1'b1;
      default: hp = 1'b0;
    endcase
    return hp;
  endfunction

endpackage
`default_nettype wire

// ----- sv/sfrp_front.sv -----
// Front end: accepts NAL bytes, tracks unit length and emulation-prevention
// zero runs, and classifies each byte for the parser. Uses sfrp_pkg.
`default_nettype none
module sfrp_front
  import sfrp_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   take_i,
  input  wire logic [7:0] data_i,
  input  wire logic   last_i,
  input  wire logic   h264_i,
  output entry_t      entry_o
);

  logic [2:0] cnt_q, cnt_d;
  logic [1:0] zrun_q, zrun_d;
  logic [2:0] cnt_inc;

  // Classify the byte and advance the counters
  always_comb begin
    cnt_inc = (cnt_q < 3'd4) ? cnt_q + 3'd1 : cnt_q;
    zrun_d  = zrun_q;
    entry_o.data   = data_i;
    entry_o.last   = last_i;
    entry_o.len_ok = (cnt_inc >= 3'd4);
    if (cnt_q == 3'd0) begin
      entry_o.kind = (h264_i && data_i[4:0] == NalTypeSps) ? K_FIRST_OK : K_FIRST_BAD;
      zrun_d = 2'd0;
    end else if (zrun_q >= 2'd2 && data_i == EpbByte) begin
      entry_o.kind = K_SKIP;
      zrun_d = 2'd0;
    end else begin
      entry_o.kind = K_FEED;
      if (data_i == 8'h00) begin
        if (zrun_q < 2'd2) zrun_d = zrun_q + 2'd1;
      end else begin
        zrun_d = 2'd0;
      end
    end
    cnt_d = last_i ? 3'd0 : cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 3'd0;
      zrun_q <= 2'd0;
    end else if (take_i) begin
      cnt_q  <= cnt_d;
      zrun_q <= zrun_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/sfrp_fifo.sv -----
// Short register queue between the front end and the parser.
// Uses sfrp_pkg for the entry type and depth.
`default_nettype none
module sfrp_fifo
  import sfrp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  entry_t    wdata_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output entry_t    rdata_o
);

  entry_t mem_q [FifoDepth];
  logic [FifoAw-1:0] wptr_q, rptr_q;
  logic [FifoAw:0]   cnt_q;

  assign full_o  = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- sv/sfrp_parse.sv -----
// Back end: bit-serial SPS/VUI walker with Exp-Golomb decoding, one bit a
// cycle in a byte, handing timing fields to the rate unit. Uses sfrp_pkg.
`default_nettype none
module sfrp_parse
  import sfrp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic empty_i,
  input  entry_t    entry_i,
  output logic      pop_o,
  output logic      req_valid_o,
  input  wire logic req_ready_i,
  output rate_req_t req_o
);

  pstate_e     st_q, st_d;
  pos_e        pos_q, pos_d;
  logic [5:0]  gz_q, gz_d, bl_q, bl_d;
  logic [31:0] acc_q, acc_d, loop_q, loop_d, uit_q, uit_d, ts_q, ts_d;
  logic        hp_q, hp_d, suf_q, suf_d;
  logic [7:0]  sh_q, sh_d;
  logic [2:0]  bcnt_q, bcnt_d;
  logic        last_q, last_d, len_q, len_d;

  logic        b, fin, fail_start;
  logic [31:0] fin_v, acc_n, loop_m1;
  logic [5:0]  w;
  pos_e        nxt;

  assign req_valid_o = (st_q == PS_REQ);
  assign req_o = '{len_ok: len_q, done: (pos_q == P_DONE), uit: uit_q, ts: ts_q};

  always_comb begin
    st_d = st_q; pos_d = pos_q; gz_d = gz_q; bl_d = bl_q; acc_d = acc_q;
    loop_d = loop_q; uit_d = uit_q; ts_d = ts_q; hp_d = hp_q; suf_d = suf_q;
    sh_d = sh_q; bcnt_d = bcnt_q; last_d = last_q; len_d = len_q;
    pop_o = 1'b0;
    b = sh_q[7];
    fin = 1'b0; fail_start = 1'b0; fin_v = '0;
    w = elem_width(pos_q);
    acc_n = {acc_q[30:0], b};
    loop_m1 = loop_q - 32'd1;
    nxt = P_FAIL;
    unique case (st_q)
      PS_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          last_d = entry_i.last;
          len_d  = entry_i.len_ok;
          sh_d   = entry_i.data;
          bcnt_d = 3'd0;
          if (entry_i.kind == K_FIRST_OK || entry_i.kind == K_FIRST_BAD) begin
            // Start of a unit: clear everything and open the first element
            pos_d = (entry_i.kind == K_FIRST_OK) ? P_PROFILE : P_FAIL;
            bl_d  = elem_width(pos_d);
            gz_d = '0; acc_d = '0; suf_d = 1'b0; hp_d = 1'b0;
            loop_d = '0; uit_d = '0; ts_d = '0;
            st_d = entry_i.last ? PS_REQ : PS_IDLE;
          end else if (entry_i.kind == K_FEED && pos_q < P_DONE) begin
            st_d = PS_BITS;
          end else begin
            st_d = entry_i.last ? PS_REQ : PS_IDLE;
          end
        end
      end
      PS_BITS: begin
        sh_d   = {sh_q[6:0], 1'b0};
        bcnt_d = bcnt_q + 3'd1;
        if (bcnt_q == 3'd7) st_d = last_q ? PS_REQ : PS_IDLE;
        // One bit of the current element
        if (pos_q < P_DONE) begin
          if (w == 6'd0 && !suf_q) begin
            if (!b) begin
              gz_d = gz_q + 6'd1;
              if (gz_q + 6'd1 >= 6'd32) fail_start = 1'b1;
            end else if (gz_q == 6'd0) begin
              fin = 1'b1;
            end else begin
              suf_d = 1'b1; bl_d = gz_q; acc_d = '0;
            end
          end else begin
            acc_d = acc_n;
            bl_d  = bl_q - 6'd1;
            if (bl_q == 6'd1) begin
              fin = 1'b1;
              fin_v = (w == 6'd0) ? ((32'd1 << gz_q) - 32'd1) + acc_n : acc_n;
            end
          end
        end
        // Syntax transitions when an element completes
        if (fin) begin
          unique case (pos_q)
            P_PROFILE: begin hp_d = high_profile(fin_v); nxt = P_CONLEV; end
            P_CONLEV:  nxt = P_SPSID;
            P_SPSID:   nxt = hp_q ? P_CHROMA : P_LOG2FN;
            P_CHROMA:  nxt = (fin_v == 32'd3) ? P_SEPCOL : P_BDL;
            P_SEPCOL:  nxt = P_BDL;
            P_BDL:     nxt = P_BDC;
            P_BDC:     nxt = P_QPB;
            P_QPB:     nxt = P_SCAL;
            P_SCAL:    nxt = (fin_v != 32'd0) ? P_FAIL : P_LOG2FN;
            P_LOG2FN:  nxt = P_POCT;
            P_POCT:    nxt = (fin_v == 32'd0) ? P_LOG2POC :
                             (fin_v == 32'd1) ? P_DELTA0 : P_MAXREF;
            P_LOG2POC: nxt = P_MAXREF;
            P_DELTA0:  nxt = P_OFFNR;
            P_OFFNR:   nxt = P_OFFTB;
            P_OFFTB:   nxt = P_NCYC;
            P_NCYC: begin
              loop_d = fin_v;
              nxt = (fin_v != 32'd0) ? P_CYCOFF : P_MAXREF;
            end
            P_CYCOFF: begin
              loop_d = loop_m1;
              nxt = (loop_m1 != 32'd0) ? P_CYCOFF : P_MAXREF;
            end
            P_MAXREF:  nxt = P_GAPS;
            P_GAPS:    nxt = P_WIDTH;
            P_WIDTH:   nxt = P_HEIGHT;
            P_HEIGHT:  nxt = P_FMO;
            P_FMO:     nxt = (fin_v != 32'd0) ? P_D8 : P_MBAFF;
            P_MBAFF:   nxt = P_D8;
            P_D8:      nxt = P_CROPF;
            P_CROPF: begin
              if (fin_v != 32'd0) begin loop_d = 32'd4; nxt = P_CROP; end
              else nxt = P_VUIF;
            end
            P_CROP: begin
              loop_d = loop_m1;
              nxt = (loop_m1 != 32'd0) ? P_CROP : P_VUIF;
            end
            P_VUIF:    nxt = (fin_v != 32'd0) ? P_ARF : P_FAIL;
            P_ARF:     nxt = (fin_v != 32'd0) ? P_ARIDC : P_OVF;
            P_ARIDC:   nxt = (fin_v == {24'd0, ArIdcExt}) ? P_SAR : P_OVF;
            P_SAR:     nxt = P_OVF;
            P_OVF:     nxt = (fin_v != 32'd0) ? P_OVA : P_VSF;
            P_OVA:     nxt = P_VSF;
            P_VSF:     nxt = (fin_v != 32'd0) ? P_VFMT : P_CLF;
            P_VFMT:    nxt = P_VFR;
            P_VFR:     nxt = P_CDF;
            P_CDF:     nxt = (fin_v != 32'd0) ? P_COLR : P_CLF;
            P_COLR:    nxt = P_CLF;
            P_CLF:     nxt = (fin_v != 32'd0) ? P_CLT : P_TIF;
            P_CLT:     nxt = P_CLB;
            P_CLB:     nxt = P_TIF;
            P_TIF:     nxt = (fin_v != 32'd0) ? P_UIT : P_FAIL;
            P_UIT: begin uit_d = fin_v; nxt = P_TS; end
            P_TS:  begin ts_d = fin_v; nxt = P_DONE; end
            default:   nxt = P_FAIL;
          endcase
        end
        if (fail_start) nxt = P_FAIL;
        if (fin || fail_start) begin
          pos_d = nxt; bl_d = elem_width(nxt); gz_d = '0; acc_d = '0; suf_d = 1'b0;
        end
      end
      PS_REQ: begin
        if (req_ready_i) begin
          st_d = PS_IDLE;
          pos_d = P_PROFILE; uit_d = '0; ts_d = '0; loop_d = '0;
          hp_d = 1'b0; suf_d = 1'b0; gz_d = '0; acc_d = '0;
          bl_d = elem_width(P_PROFILE);
        end
      end
      default: st_d = PS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PS_IDLE; pos_q <= P_PROFILE; gz_q <= '0; bl_q <= 6'd8;
      acc_q <= '0; loop_q <= '0; uit_q <= '0; ts_q <= '0; hp_q <= 1'b0;
      suf_q <= 1'b0; bcnt_q <= '0; last_q <= 1'b0; len_q <= 1'b0;
    end else begin
      st_q <= st_d; pos_q <= pos_d; gz_q <= gz_d; bl_q <= bl_d;
      acc_q <= acc_d; loop_q <= loop_d; uit_q <= uit_d; ts_q <= ts_d; hp_q <= hp_d;
      suf_q <= suf_d; bcnt_q <= bcnt_d; last_q <= last_d; len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

endmodule
`default_nettype wire

// ----- sv/sfrp_rate.sv -----
// Rate unit: binary gcd, two bit-serial divisions, range check by
// cross-multiplication and the output register. Uses sfrp_pkg.
`default_nettype none
module sfrp_rate
  import sfrp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       req_valid_i,
  output logic            req_ready_o,
  input  rate_req_t       req_i,
  input  wire logic [9:0] min_fps_i,
  input  wire logic [9:0] max_fps_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [63:0]     out_data_o
);

  rstate_e     st_q, st_d;
  logic [30:0] ts_q, d2_q, a_q, b_q, g_q, q_q, n_q, den_q;
  logic [30:0] r_q;
  logic [4:0]  k_q, cnt_q;
  logic [40:0] lo_q, hi_q;
  logic        res_v_q;
  logic        ov_q;
  logic [62:0] od_q;

  logic        pre_ok;
  logic [31:0] tmp;
  logic        ge;

  assign req_ready_o = (st_q == RS_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = {1'b0, od_q};

  assign pre_ok = req_i.len_ok && req_i.done && req_i.uit != '0 && req_i.ts != '0 &&
                  req_i.ts <= RateLimit && req_i.uit <= UnitsLimit;

  // Restoring division step, one quotient bit a cycle
  assign tmp = {r_q, q_q[30]};
  assign ge  = (tmp >= {1'b0, g_q});

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      RS_IDLE: if (req_valid_i) st_d = pre_ok ? RS_GCD : RS_OUT;
      RS_GCD:  if (a_q == b_q) st_d = RS_DIVN;
      RS_DIVN: if (cnt_q == 5'd30) st_d = RS_DIVD;
      RS_DIVD: if (cnt_q == 5'd30) st_d = RS_MUL;
      RS_MUL:  st_d = RS_CMP;
      RS_CMP:  st_d = RS_OUT;
      RS_OUT:  if (!ov_q || out_ready_i) st_d = RS_IDLE;
      default: st_d = RS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= RS_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == RS_OUT && (!ov_q || out_ready_i)) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      RS_IDLE: begin
        ts_q <= req_i.ts[30:0];
        d2_q <= {req_i.uit[29:0], 1'b0};
        a_q  <= req_i.ts[30:0];
        b_q  <= {req_i.uit[29:0], 1'b0};
        k_q  <= '0;
        res_v_q <= 1'b0;
      end
      RS_GCD: begin
        if (a_q == b_q) begin
          g_q   <= a_q << k_q;
          r_q   <= '0;
          q_q   <= ts_q;
          cnt_q <= '0;
        end else if (!a_q[0] && !b_q[0]) begin
          a_q <= a_q >> 1; b_q <= b_q >> 1; k_q <= k_q + 5'd1;
        end else if (!a_q[0]) begin
          a_q <= a_q >> 1;
        end else if (!b_q[0]) begin
          b_q <= b_q >> 1;
        end else if (a_q > b_q) begin
          a_q <= (a_q - b_q) >> 1;
        end else begin
          b_q <= (b_q - a_q) >> 1;
        end
      end
      RS_DIVN, RS_DIVD: begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd30) begin
          r_q <= '0;
          q_q <= d2_q;
          cnt_q <= '0;
          if (st_q == RS_DIVN) n_q <= {q_q[29:0], ge};
          else den_q <= {q_q[29:0], ge};
        end else begin
          r_q <= ge ? 31'(tmp - {1'b0, g_q}) : tmp[30:0];
          q_q <= {q_q[29:0], ge};
        end
      end
      RS_MUL: begin
        lo_q <= {10'd0, den_q} * {31'd0, min_fps_i};
        hi_q <= {10'd0, den_q} * {31'd0, max_fps_i};
      end
      RS_CMP: res_v_q <= ({10'd0, n_q} >= lo_q) && ({10'd0, n_q} <= hi_q);
      RS_OUT: begin
        if (!ov_q || out_ready_i) begin
          od_q <= res_v_q ? {den_q, n_q, 1'b1} : '0;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/h264_sps_frame_rate_parser_top.sv -----
// Top level of the H.264 SPS frame rate parser: configuration registers and
// the front end, queue, bit-serial parser and rate unit. Uses sfrp_pkg.
//
// Feed one NAL unit a byte per request, tlast on its final byte; exactly one
// result follows each final byte. The front end takes a byte every cycle
// until its four-entry queue fills; the parser takes each byte it walks
// from the queue, then decodes it one Exp-Golomb bit a cycle, and only takes
// skipped or ignored bytes from the queue. After the final byte the rate
// unit runs a binary gcd, two bit-serial divisions, then multiply, compare
// and output; a request that fails its checks goes straight to output.
`default_nettype none
module h264_sps_frame_rate_parser_top
  import sfrp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // last_byte
  input  wire logic        s_axis_tuser,   // [0] is_h264
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [0] valid_res, [31:1] rate_num, [62:32] rate_den
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [9:0]  cfg_wdata_i
);

  logic [9:0] min_fps_q, max_fps_q;
  logic       full, empty, take, pop, req_valid, req_ready;
  entry_t     f_entry, q_entry;
  rate_req_t  req;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_fps_q <= 10'd12;
      max_fps_q <= 10'd240;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgMinFps: min_fps_q <= cfg_wdata_i;
        CfgMaxFps: max_fps_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign take = s_axis_tvalid && !full;

  sfrp_front u_front (
    .clk_i, .rst_ni, .take_i(take), .data_i(s_axis_tdata),
    .last_i(s_axis_tlast), .h264_i(s_axis_tuser), .entry_o(f_entry)
  );

  sfrp_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(take), .wdata_i(f_entry), .full_o(full),
    .pop_i(pop), .empty_o(empty), .rdata_o(q_entry)
  );

  sfrp_parse u_parse (
    .clk_i, .rst_ni, .empty_i(empty), .entry_i(q_entry), .pop_o(pop),
    .req_valid_o(req_valid), .req_ready_i(req_ready), .req_o(req)
  );

  sfrp_rate u_rate (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .min_fps_i(min_fps_q), .max_fps_i(max_fps_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata)
  );

endmodule
`default_nettype wire

// ----- bench/sps_rate_checker.sv -----
// Checker for the H.264 SPS frame rate parser: watches both stream channels
// and the configuration port, predicts each result and compares it.
// Depends on sfrp_pkg for the syntax element codes and register indexes.
`timescale 1ns / 100ps
module sps_rate_checker
  import sfrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [9:0]  cfg_wdata_i,
  output int          fails_o,
  output int          rates_pending_o
);

  typedef struct packed {
    logic        ok;
    logic [30:0] num;
    logic [30:0] den;
  } rate_t;

  rate_t rates_due[$];

  // predictor copy of the block state
  logic [9:0]  lo_fps, hi_fps;
  logic [2:0]  nbytes;
  logic [1:0]  zrun;
  pos_e        pos;
  logic [5:0]  bits_due, gz;
  logic [31:0] acc, loops, uit, ts;
  logic        hp, in_suffix;

  initial begin
    fails_o = 0;
    rates_pending_o = 0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    fails_o++;
  endtask

  // width of a fixed-length element, zero for ue(v)
  function automatic int field_width(pos_e p);
    case (p)
      P_PROFILE, P_ARIDC: return 8;
      P_CONLEV:           return 16;
      P_VFMT:             return 3;
      P_COLR:             return 24;
      P_SAR, P_UIT, P_TS: return 32;
      P_SEPCOL, P_QPB, P_SCAL, P_DELTA0, P_GAPS, P_FMO, P_MBAFF, P_D8, P_CROPF,
      P_VUIF, P_ARF, P_OVA, P_OVF, P_VSF, P_VFR, P_CDF, P_CLF, P_TIF: return 1;
      default:            return 0;
    endcase
  endfunction

  function automatic logic [31:0] gcd32(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  task automatic begin_field(input pos_e p);
    pos = p;
    bits_due = 6'(field_width(p));
    gz = 0;
    acc = 0;
    in_suffix = 0;
  endtask

  task automatic clear_nal();
    nbytes = 0;
    zrun = 0;
    hp = 0;
    loops = 0;
    uit = 0;
    ts = 0;
    begin_field(P_PROFILE);
  endtask

  // choose the next element from the one just completed
  task automatic end_field(input logic [31:0] v);
    pos_e nxt;
    nxt = P_FAIL;
    case (pos)
      P_PROFILE: begin
        hp = v inside {44, 83, 86, 100, 110, 118, 122, 128, 134, 138, 139, 244};
        nxt = P_CONLEV;
      end
      P_CONLEV:  nxt = P_SPSID;
      P_SPSID:   nxt = hp ? P_CHROMA : P_LOG2FN;
      P_CHROMA:  nxt = (v == 3) ? P_SEPCOL : P_BDL;
      P_SEPCOL:  nxt = P_BDL;
      P_BDL:     nxt = P_BDC;
      P_BDC:     nxt = P_QPB;
      P_QPB:     nxt = P_SCAL;
      P_SCAL:    nxt = (v != 0) ? P_FAIL : P_LOG2FN;
      P_LOG2FN:  nxt = P_POCT;
      P_POCT:    nxt = (v == 0) ? P_LOG2POC : (v == 1) ? P_DELTA0 : P_MAXREF;
      P_LOG2POC: nxt = P_MAXREF;
      P_DELTA0:  nxt = P_OFFNR;
      P_OFFNR:   nxt = P_OFFTB;
      P_OFFTB:   nxt = P_NCYC;
      P_NCYC: begin
        loops = v;
        nxt = (v != 0) ? P_CYCOFF : P_MAXREF;
      end
      P_CYCOFF: begin
        loops = loops - 1;
        nxt = (loops != 0) ? P_CYCOFF : P_MAXREF;
      end
      P_MAXREF:  nxt = P_GAPS;
      P_GAPS:    nxt = P_WIDTH;
      P_WIDTH:   nxt = P_HEIGHT;
      P_HEIGHT:  nxt = P_FMO;
      P_FMO:     nxt = (v != 0) ? P_D8 : P_MBAFF;
      P_MBAFF:   nxt = P_D8;
      P_D8:      nxt = P_CROPF;
      P_CROPF: begin
        if (v != 0) begin
          loops = 4;
          nxt = P_CROP;
        end else nxt = P_VUIF;
      end
      P_CROP: begin
        loops = loops - 1;
        nxt = (loops != 0) ? P_CROP : P_VUIF;
      end
      P_VUIF:    nxt = (v != 0) ? P_ARF : P_FAIL;
      P_ARF:     nxt = (v != 0) ? P_ARIDC : P_OVF;
      P_ARIDC:   nxt = (v == 255) ? P_SAR : P_OVF;
      P_SAR:     nxt = P_OVF;
      P_OVF:     nxt = (v != 0) ? P_OVA : P_VSF;
      P_OVA:     nxt = P_VSF;
      P_VSF:     nxt = (v != 0) ? P_VFMT : P_CLF;
      P_VFMT:    nxt = P_VFR;
      P_VFR:     nxt = P_CDF;
      P_CDF:     nxt = (v != 0) ? P_COLR : P_CLF;
      P_COLR:    nxt = P_CLF;
      P_CLF:     nxt = (v != 0) ? P_CLT : P_TIF;
      P_CLT:     nxt = P_CLB;
      P_CLB:     nxt = P_TIF;
      P_TIF:     nxt = (v != 0) ? P_UIT : P_FAIL;
      P_UIT: begin
        uit = v;
        nxt = P_TS;
      end
      P_TS: begin
        ts = v;
        nxt = P_DONE;
      end
      default:   nxt = P_FAIL;
    endcase
    begin_field(nxt);
  endtask

  // one payload bit into the syntax walk
  task automatic push_bit(input logic b);
    if (pos >= P_DONE) return;
    if (field_width(pos) == 0 && !in_suffix) begin
      if (!b) begin
        gz = gz + 1;
        if (gz >= 32) begin_field(P_FAIL);
      end else if (gz == 0) begin
        end_field(0);
      end else begin
        in_suffix = 1;
        bits_due = gz;
        acc = 0;
      end
      return;
    end
    acc = {acc[30:0], b};
    bits_due = bits_due - 1;
    if (bits_due == 0) begin
      if (field_width(pos) == 0) end_field(((32'd1 << gz) - 1) + acc);
      else end_field(acc);
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last, input logic h264);
    rate_t       r;
    logic [31:0] d2, g;
    logic [63:0] n, d;
    if (nbytes == 0) begin
      begin_field((h264 && b[4:0] == NalTypeSps) ? P_PROFILE : P_FAIL);
      zrun = 0;
      nbytes = 1;
    end else begin
      if (nbytes < 4) nbytes++;
      if (pos < P_DONE) begin
        if (zrun >= 2 && b == EpbByte) zrun = 0;
        else begin
          if (b == 0) begin
            if (zrun < 2) zrun++;
          end else zrun = 0;
          for (int i = 7; i >= 0; i--) push_bit(b[i]);
        end
      end
    end
    if (!last) return;
    r = '0;
    if (nbytes >= 4 && pos == P_DONE && uit != 0 && ts != 0 &&
        ts <= 32'd2000000000 && uit <= 32'd1000000000) begin
      d2 = uit * 2;
      g = gcd32(ts, d2);
      n = 64'(ts / g);
      d = 64'(d2 / g);
      if (n >= 64'(lo_fps) * d && n <= 64'(hi_fps) * d) begin
        r.ok = 1;
        r.num = n[30:0];
        r.den = d[30:0];
      end
    end
    rates_due.push_back(r);
    clear_nal();
  endtask

  // results first, then the request taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    rate_t want;
    if (!rst_ni) begin
      lo_fps = 10'd12;
      hi_fps = 10'd240;
      clear_nal();
      rates_due.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (rates_due.size() == 0) begin
          report("unexpected result, valid_res", 32'(m_tdata_i[0]), 0);
        end else begin
          want = rates_due.pop_front();
          if (m_tdata_i[0] !== want.ok) report("valid_res", 32'(m_tdata_i[0]), 32'(want.ok));
          if (m_tdata_i[31:1] !== want.num)
            report("rate_num", 32'(m_tdata_i[31:1]), 32'(want.num));
          if (m_tdata_i[62:32] !== want.den)
            report("rate_den", 32'(m_tdata_i[62:32]), 32'(want.den));
        end
      end
      if (s_tvalid_i && s_tready_i) take_byte(s_tdata_i, s_tlast_i, s_tuser_i);
      if (cfg_we_i) begin
        if (cfg_addr_i == CfgMinFps) lo_fps = cfg_wdata_i;
        else hi_fps = cfg_wdata_i;
      end
    end
    rates_pending_o = rates_due.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the frame rate parser bench: clock, reset, NAL unit stimulus,
// receiver stalls and the verdict. Uses sfrp_pkg and sps_rate_checker.
`timescale 1ns / 100ps
module testbench;
  import sfrp_pkg::*;

  localparam int F_NONE    = 0;
  localparam int F_SCALING = 1;
  localparam int F_NOVUI   = 2;
  localparam int F_NOTIF   = 3;
  localparam int F_LONGPFX = 4;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        s_tvalid = 0, s_tlast = 0, s_tuser = 0;
  logic [7:0]  s_tdata = 0;
  logic        s_tready;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;
  logic        cfg_we = 0, cfg_addr = 0;
  logic [9:0]  cfg_wdata = 0;
  int          fails, pending;
  int          tx_pct = 0, rx_pct = 0, hold_cycles = 0;
  int          lo = 12, hi = 240, nbytes_sent = 0, nframes = 0;
  logic        bits_q[$];
  logic [7:0]  nal_q[$];

  h264_sps_frame_rate_parser_top uut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .s_axis_tlast(s_tlast), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata)
  );

  sps_rate_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .s_tlast_i(s_tlast), .s_tuser_i(s_tuser),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .fails_o(fails), .rates_pending_o(pending)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    #6_000_000;
    $display("FAIL h264_sps_frame_rate_parser_top");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when asked
  initial forever begin
    @(negedge clk);
    if (hold_cycles > 0) begin
      m_tready <= 0;
      hold_cycles--;
    end else m_tready <= ($urandom_range(99) >= rx_pct);
  end

  task automatic put_bits(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) bits_q.push_back(v[i]);
  endtask

  task automatic put_ue(input logic [31:0] v);
    logic [32:0] c;
    int          len;
    c = 33'(v) + 1;
    len = 0;
    for (int i = 0; i < 33; i++) if (c[i]) len = i + 1;
    repeat (len - 1) bits_q.push_back(0);
    for (int i = len - 1; i >= 0; i--) bits_q.push_back(c[i]);
  endtask

  // bits to bytes with emulation prevention, header first
  task automatic pack_nal(input logic [7:0] hdr);
    logic [7:0] b;
    int         zc;
    while (bits_q.size() % 8 != 0) bits_q.push_back(0);
    nal_q.delete();
    nal_q.push_back(hdr);
    zc = 0;
    for (int i = 0; i < bits_q.size(); i += 8) begin
      for (int k = 0; k < 8; k++) b[7 - k] = bits_q[i + k];
      if (zc >= 2 && b <= 8'h03) begin
        nal_q.push_back(EpbByte);
        zc = 0;
      end
      nal_q.push_back(b);
      zc = (b == 0) ? zc + 1 : 0;
    end
  endtask

  task automatic make_sps(input int flaw, input logic [31:0] units, input logic [31:0] scale);
    logic [7:0] prof;
    logic       hpf, cf, ar;
    int         poc, ncyc;
    bits_q.delete();
    case ($urandom_range(8))
      0: prof = 66;  1: prof = 77;  2: prof = 88;  3: prof = 100; 4: prof = 110;
      5: prof = 122; 6: prof = 244; 7: prof = 44;  default: prof = $urandom_range(255);
    endcase
    if (flaw == F_SCALING) prof = 100;
    hpf = prof inside {44, 83, 86, 100, 110, 118, 122, 128, 134, 138, 139, 244};
    put_bits(prof, 8);
    put_bits($urandom, 16);
    if (flaw == F_LONGPFX) begin
      repeat (32) bits_q.push_back(0);
      put_bits($urandom, 24);
      return;
    end
    put_ue($urandom_range(31));
    if (hpf) begin
      cf = $urandom_range(3) == 3;
      put_ue(cf ? 3 : $urandom_range(2));
      if (cf) put_bits($urandom, 1);
      put_ue($urandom_range(6));
      put_ue($urandom_range(6));
      put_bits($urandom, 1);
      put_bits((flaw == F_SCALING) ? 1 : 0, 1);
    end
    put_ue($urandom_range(12));
    poc = $urandom_range(2);
    put_ue(poc);
    if (poc == 0) put_ue($urandom_range(12));
    else if (poc == 1) begin
      put_bits($urandom, 1);
      put_ue($urandom_range(300));
      put_ue($urandom_range(300));
      ncyc = $urandom_range(3);
      put_ue(ncyc);
      repeat (ncyc) put_ue($urandom_range(100));
    end
    put_ue($urandom_range(16));
    put_bits($urandom, 1);
    put_ue($urandom_range(240));
    put_ue($urandom_range(135));
    cf = $urandom_range(1);
    put_bits(cf, 1);
    if (!cf) put_bits($urandom, 1);
    put_bits($urandom, 1);
    cf = $urandom_range(1);
    put_bits(cf, 1);
    if (cf) repeat (4) put_ue($urandom_range(20));
    put_bits((flaw == F_NOVUI) ? 0 : 1, 1);
    if (flaw == F_NOVUI) begin
      put_bits($urandom, 32);
      return;
    end
    ar = $urandom_range(1);
    put_bits(ar, 1);
    if (ar) begin
      cf = $urandom_range(1);
      put_bits(cf ? 8'd255 : 8'($urandom), 8);
      if (cf) put_bits($urandom, 32);
    end
    cf = $urandom_range(1);
    put_bits(cf, 1);
    if (cf) put_bits($urandom, 1);
    cf = $urandom_range(1);
    put_bits(cf, 1);
    if (cf) begin
      put_bits($urandom, 4);
      ar = $urandom_range(1);
      put_bits(ar, 1);
      if (ar) put_bits($urandom, 24);
    end
    cf = $urandom_range(1);
    put_bits(cf, 1);
    if (cf) begin
      put_ue($urandom_range(5));
      put_ue($urandom_range(5));
    end
    put_bits((flaw == F_NOTIF) ? 0 : 1, 1);
    put_bits(units, 32);
    put_bits(scale, 32);
    // stop bit, then now and then some trailing bits
    bits_q.push_back(1);
    if ($urandom_range(3) == 0) repeat ($urandom_range(24)) bits_q.push_back($urandom_range(1));
  endtask

  // timing pair around the current fps window, with extremes now and then
  task automatic pick_timing(output logic [31:0] units, output logic [31:0] scale);
    int r;
    r = $urandom_range(99);
    units = $urandom_range(1, 5000);
    if (r < 40) scale = 2 * units * $urandom_range(1, 1100);
    else if (r < 55) begin
      units = 1001 * $urandom_range(1, 3);
      scale = units / 1001 * 2000 * $urandom_range(1, 300);
    end else if (r < 75) begin
      scale = 2 * units * ($urandom_range(1) ? lo : hi);
      scale = scale + $urandom_range(2) - 1;
    end else if (r < 90) begin
      units = $urandom_range(1, 100000);
      scale = $urandom_range(1, 2000000);
    end else begin
      case ($urandom_range(3))
        0: scale = 0;  1: scale = 32'd2000000000;
        2: scale = 32'd2000000001; default: scale = 32'hFFFFFFFF;
      endcase
      case ($urandom_range(3))
        0: units = 0;  1: units = 1;
        2: units = 32'd1000000000; default: units = 32'd1000000001;
      endcase
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic h264);
    while ($urandom_range(99) < tx_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= b;
    s_tlast <= last;
    s_tuser <= h264;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    nbytes_sent++;
  endtask

  task automatic send_nal(input logic h264);
    for (int i = 0; i < nal_q.size(); i++)
      send_byte(nal_q[i], i == nal_q.size() - 1, (i == 0) ? h264 : 1'($urandom));
    s_tvalid <= 0;
    nframes++;
  endtask

  task automatic sps_nal(input int flaw, input logic [31:0] units, input logic [31:0] scale);
    make_sps(flaw, units, scale);
    pack_nal(8'h67);
    send_nal(1);
  endtask

  task automatic wait_idle();
    wait (pending == 0);
    repeat (200) @(negedge clk);
  endtask

  task automatic cfg_write(input logic addr, input logic [9:0] v);
    cfg_we <= 1;
    cfg_addr <= addr;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // one random unit: mostly well-formed, the rest broken or noise
  task automatic random_nal();
    logic [31:0] u, t;
    int          r, f, keep;
    r = $urandom_range(99);
    f = F_NONE;
    if (r < 4) f = $urandom_range(F_SCALING, F_LONGPFX);
    pick_timing(u, t);
    make_sps(f, u, t);
    pack_nal({3'($urandom), 5'd7});
    if (r >= 80 && r < 86) begin
      keep = $urandom_range(1, nal_q.size() - 1);
      while (nal_q.size() > keep) void'(nal_q.pop_back());
    end else if (r >= 86 && r < 91) begin
      nal_q.delete();
      repeat ($urandom_range(1, 30)) nal_q.push_back($urandom);
    end else if (r >= 91 && r < 94) begin
      nal_q[0] = {3'($urandom), 5'($urandom_range(8, 31))};
    end else if (r >= 94 && r < 97) begin
      while (nal_q.size() > $urandom_range(1, 3)) void'(nal_q.pop_back());
    end else if (r >= 97) begin
      nal_q[$urandom_range(1, nal_q.size() - 1)] ^= 8'(1 << $urandom_range(7));
    end
    send_nal(r < 97 && r >= 94 ? 1'($urandom) : (r == 93 ? 1'b0 : 1'b1));
  endtask

  initial begin
    int phase_lo[6];
    int phase_hi[6];
    phase_lo = '{1, 0, 500, 30, 1023, 24};
    phase_hi = '{1000, 1023, 100, 30, 1023, 60};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: typical rate, window edges, each invalid case
    sps_nal(F_NONE, 1001, 60000);
    sps_nal(F_NONE, 7, 2 * 7 * 12);
    sps_nal(F_NONE, 7, 2 * 7 * 12 - 1);
    sps_nal(F_NONE, 3, 2 * 3 * 240);
    sps_nal(F_NONE, 3, 2 * 3 * 240 + 1);
    sps_nal(F_SCALING, 1, 60);
    sps_nal(F_NOVUI, 1, 60);
    sps_nal(F_NOTIF, 1, 60);
    sps_nal(F_LONGPFX, 1, 60);
    sps_nal(F_NONE, 1, 0);
    sps_nal(F_NONE, 0, 60);
    sps_nal(F_NONE, 1, 32'd2000000001);
    sps_nal(F_NONE, 32'd1000000001, 32'd2000000000);
    sps_nal(F_NONE, 32'd1000000000, 32'd2000000000);
    sps_nal(F_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF);
    make_sps(F_NONE, 1, 50);
    while (nal_q.size() > 10) void'(nal_q.pop_back());
    send_nal(1);
    make_sps(F_NONE, 1, 50);
    pack_nal(8'hE1);
    send_nal(1);
    make_sps(F_NONE, 1, 50);
    pack_nal(8'h67);
    send_nal(0);
    nal_q = '{8'h67};
    send_nal(1);
    nal_q = '{8'h67, 8'h00, 8'hFF};
    send_nal(1);
    nal_q = '{8'h67, 8'h00, 8'h00, 8'h03};
    send_nal(1);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      lo = phase_lo[ph];
      hi = phase_hi[ph];
      cfg_write(CfgMinFps, 10'(lo));
      cfg_write(CfgMaxFps, 10'(hi));
      case (ph / 2)
        0: begin tx_pct = 8;  rx_pct = 75; end
        1: begin tx_pct = 75; rx_pct = 8;  end
        default: begin tx_pct = 0; rx_pct = 0; end
      endcase
      for (int k = 0; k < ((ph == 1) ? 3 : 1) || (ph == 5 && nbytes_sent < 600); k++) begin
        // long receiver hold-off while several units queue up behind it
        if (ph == 1 && k == 0) hold_cycles = 1500;
        random_nal();
      end
    end

    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (fails == 0) $display("PASS h264_sps_frame_rate_parser_top");
    else $display("FAIL h264_sps_frame_rate_parser_top");
    $finish;
  end

endmodule
